// File: rtl/atprm_pkg.sv
// Shared types and constants for the true-peak / RMS level meter.
package atprm_pkg;

    localparam int LEVEL_W = 24;
    localparam int CH_W    = 3;
    localparam int CFG_W   = 13;
    localparam int COEF_W  = 24;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    typedef enum logic [0:0] {
        CFG_PEAK_MODE    = 1'b0,
        CFG_BLOCK_LENGTH = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]    out_channel;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] rms_level;
    } t_out_item;

    // Interpolation coefficients, Q0.23, row k tap j.
    function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] k, input logic [1:0] j);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case ({k, j})
            4'h0: c = -24'sd871937;
            4'h1: c = 24'sd1961861;
            4'h2: c = 24'sd7847451;
            4'h3: c = -24'sd1307910;
            4'h4: c = -24'sd1587183;
            4'h5: c = 24'sd4232481;
            4'h6: c = 24'sd6348725;
            4'h7: c = -24'sd1813919;
            4'h8: c = -24'sd1813919;
            4'h9: c = 24'sd6348725;
            4'ha: c = 24'sd4232481;
            4'hb: c = -24'sd1587183;
            4'hc: c = -24'sd1307910;
            4'hd: c = 24'sd7847451;
            4'he: c = 24'sd1961861;
            4'hf: c = -24'sd871937;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/atprm_if.sv
// Valid/ready stream interface carrying one request payload.
interface atprm_if #(
    parameter int W = 27
) (
    input logic i_clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/audio_true_peak_rms_meter.sv
// Per-channel sample/true peak and RMS meter with a shared multiply-accumulate unit.
// Per request: a history-max pass over four history entries, a square step, 20 MAC/fold steps in true-peak
// mode and a close step; the next request is taken only once the meter is back in idle.
// Block close adds a 64-bit restoring division and a square root; the result is held
// valid until it is taken, and input holds off until then.
// Reset (synchronous, active low) clears history, peaks, sums, counts and control state.
module audio_true_peak_rms_meter #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_BLOCK   = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    atprm_if.sink                   s_in,
    atprm_if.source                 m_out,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [atprm_pkg::CFG_W-1:0] i_cfg_data
);
    import atprm_pkg::*;

    localparam int SW   = SAMPLE_BITS;
    localparam int CIDX = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SQW  = 2 * SW;
    localparam int SUMW = 64;
    localparam int ACCW = SW + COEF_W + 2;
    localparam int LW   = CFG_W;
    localparam logic [LW-1:0] MAXB = (MAX_BLOCK > 8191) ? LW'(8191) : LW'(MAX_BLOCK);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INIT = 7'b0000010,
        S_SQ   = 7'b0000100,
        S_MAC  = 7'b0001000,
        S_DONE = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_SQRT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic r_mode;
    logic [LW-1:0] r_blen;
    logic signed [SW-1:0] r_hist [CHANNELS][4];
    logic [LEVEL_W-1:0]   r_peak [CHANNELS];
    logic [SUMW-1:0]      r_sum  [CHANNELS];
    logic [LW-1:0]        r_cnt  [CHANNELS];

    logic [CIDX-1:0] r_ch;
    logic [CH_W-1:0] r_ch_out;
    logic signed [SW-1:0] r_s;
    logic [LEVEL_W-1:0] r_pk;
    logic [3:0] r_step;
    logic signed [ACCW-1:0] r_acc;
    logic [SUMW-1:0] r_rem, r_quo, r_div_d;
    logic [LW-1:0] r_len;
    logic [6:0] r_it;
    logic [SUMW-1:0] r_sx, r_sr, r_sbit;
    logic r_ovalid;
    t_out_item r_out;

    t_in_item in_item;
    assign in_item = t_in_item'(s_in.data);

    // Shared multiplier operands.
    logic signed [SW:0]       mul_a;
    logic signed [COEF_W:0]   mul_b;
    logic signed [SW+COEF_W+1:0] mul_p;
    logic signed [COEF_W-1:0] cval;
    logic [SW-1:0] abs_s;
    logic signed [SW-1:0] hsel;
    logic [1:0] hj;
    logic signed [SW-1:0] shifted [4];
    logic [SW:0] hmag;
    logic [LEVEL_W-1:0] hm_sat;
    logic [ACCW-1:0] acc_mag;
    logic [ACCW-24:0] rnd;
    logic [LEVEL_W-1:0] rnd_sat;
    logic [SUMW:0] div_try;
    logic [SUMW-1:0] sq_try;
    logic [LW-1:0] eff_len;

    always_comb begin
        shifted[0] = r_hist[r_ch][1];
        shifted[1] = r_hist[r_ch][2];
        shifted[2] = r_hist[r_ch][3];
        shifted[3] = r_s;
        hj = r_step[1:0];
        // INIT reads the old history, MAC the history already shifted in SQ
        hsel = r_hist[r_ch][hj];
        hmag = hsel[SW-1] ? (SW+1)'(-$signed({hsel[SW-1], hsel})) : {1'b0, hsel};
        hm_sat = (hmag > (SW+1)'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(hmag);
        abs_s = r_s[SW-1] ? SW'(-r_s) : SW'(r_s);
        cval = coef(r_step[3:2], hj);
        if (r_state == S_SQ) begin
            mul_a = $signed({1'b0, abs_s});
            mul_b = $signed((COEF_W+1)'({1'b0, abs_s}));
        end else begin
            mul_a = $signed({hsel[SW-1], hsel});
            mul_b = $signed({cval[COEF_W-1], cval});
        end
        mul_p = mul_a * mul_b;
        acc_mag = r_acc[ACCW-1] ? ACCW'(-r_acc) : ACCW'(r_acc);
        rnd = (ACCW-23)'((acc_mag + ACCW'(1 << 22)) >> 23);
        rnd_sat = (rnd > (ACCW-23)'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(rnd);
        div_try = {r_rem[SUMW-2:0], r_div_d[SUMW-1]} - {{(SUMW-LW+1){1'b0}}, r_len};
        sq_try = r_sr + r_sbit;
    end

    assign s_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;

    assign eff_len = (r_blen < LW'(4)) ? LW'(4) : (r_blen > MAXB) ? MAXB : r_blen;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_in.valid && s_in.ready && 32'(in_item.channel) < CHANNELS)
                        n_state = S_INIT;
            S_INIT: if (r_step[1:0] == 2'd3) n_state = S_SQ;
            S_SQ:   n_state = r_mode ? S_MAC : S_DONE;
            S_MAC:  if (r_step == 4'd15 && r_it[0]) n_state = S_DONE;
            S_DONE: n_state = (r_cnt[r_ch] < eff_len) ? S_IDLE : S_DIV;
            S_DIV:  if (r_it == 7'd63) n_state = S_SQRT;
            S_SQRT: if (r_sbit == '0) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= 1'b0;
            r_blen <= LW'(1024);
            r_ovalid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                for (int k = 0; k < 4; k++) r_hist[c][k] <= '0;
                r_peak[c] <= '0;
                r_sum[c] <= '0;
                r_cnt[c] <= '0;
            end
            r_step <= '0;
            r_it <= '0;
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_PEAK_MODE) r_mode <= i_cfg_data[0];
                else r_blen <= i_cfg_data;
            end
            if (r_state == S_SQRT && n_state == S_IDLE) r_ovalid <= 1'b1;
            else if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    r_it <= '0;
                    if (s_in.valid && s_in.ready) begin
                        r_ch <= CIDX'(in_item.channel);
                        r_ch_out <= in_item.channel;
                        r_s <= SW'(in_item.sample);
                        r_pk <= (r_cnt[CIDX'(in_item.channel)] == '0) ? '0
                              : r_peak[CIDX'(in_item.channel)];
                    end
                end
                S_INIT: begin
                    // history max only applies at block start
                    if (r_cnt[r_ch] == '0 && hm_sat > r_pk) r_pk <= hm_sat;
                    r_step <= (r_step[1:0] == 2'd3) ? '0 : r_step + 4'd1;
                end
                S_SQ: begin
                    r_hist[r_ch][0] <= shifted[0];
                    r_hist[r_ch][1] <= shifted[1];
                    r_hist[r_ch][2] <= shifted[2];
                    r_hist[r_ch][3] <= shifted[3];
                    if (LEVEL_W'(abs_s) > r_pk) r_pk <= LEVEL_W'(abs_s);
                    r_sum[r_ch] <= (r_sum[r_ch] > ~SUMW'(SQW'(mul_p))) ? '1
                                 : r_sum[r_ch] + SUMW'(SQW'(mul_p));
                    r_cnt[r_ch] <= r_cnt[r_ch] + LW'(1);
                    r_acc <= '0;
                    r_it <= '0;
                end
                S_MAC: begin
                    // accumulate the four taps of a row, then fold the rounded result into peak
                    if (!r_it[0]) begin
                        r_acc <= r_acc + ACCW'(mul_p);
                        r_it[0] <= (r_step[1:0] == 2'd3);
                        if (r_step[1:0] != 2'd3) r_step <= r_step + 4'd1;
                    end else begin
                        if (rnd_sat > r_pk) r_pk <= rnd_sat;
                        r_acc <= '0;
                        r_it[0] <= 1'b0;
                        r_step <= r_step + 4'd1;
                    end
                end
                S_DONE: begin
                    r_it <= '0;
                    r_len <= eff_len;
                    if (r_cnt[r_ch] < eff_len) begin
                        r_peak[r_ch] <= r_pk;
                    end else begin
                        r_div_d <= r_sum[r_ch];
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt[r_ch] <= '0;
                        r_sum[r_ch] <= '0;
                        r_peak[r_ch] <= '0;
                    end
                end
                S_DIV: begin
                    r_div_d <= r_div_d << 1;
                    if (!div_try[SUMW]) begin
                        r_rem <= div_try[SUMW-1:0];
                        r_quo <= {r_quo[SUMW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[SUMW-2:0], r_div_d[SUMW-1]};
                        r_quo <= {r_quo[SUMW-2:0], 1'b0};
                    end
                    r_it <= r_it + 7'd1;
                    if (r_it == 7'd63) begin
                        r_sx <= '0;
                        r_sr <= '0;
                        r_sbit <= SUMW'(1) << 62;
                    end
                end
                S_SQRT: begin
                    if (r_it == 7'd64) begin
                        r_sx <= r_quo;
                        r_it <= 7'd65;
                    end else if (r_sbit != '0) begin
                        if (r_sx >= sq_try) begin
                            r_sx <= r_sx - sq_try;
                            r_sr <= (r_sr >> 1) + r_sbit;
                        end else r_sr <= r_sr >> 1;
                        r_sbit <= r_sbit >> 2;
                    end
                    if (n_state == S_IDLE) begin
                        r_out.out_channel <= r_ch_out;
                        r_out.peak_level <= r_pk;
                        r_out.rms_level <= (r_sr > SUMW'(LEVEL_MAX)) ? LEVEL_MAX
                                         : LEVEL_W'(r_sr);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the true-peak / RMS level meter.
`timescale 1ns / 100ps

module tb_top;
    import atprm_pkg::*;

    localparam int NCH       = 8;
    localparam int MAX_BLK   = 4096;
    localparam int WDOG_MAX  = 20000;
    localparam int TAIL_CYC  = 150;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    atprm_if #(.W(CH_W + LEVEL_W)) s_in (.i_clk(i_clk));
    atprm_if #(.W(CH_W + 2 * LEVEL_W)) m_out (.i_clk(i_clk));

    audio_true_peak_rms_meter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (s_in),
        .m_out      (m_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state
    logic signed [LEVEL_W-1:0] hist [NCH][4];
    logic [LEVEL_W-1:0]        peak_acc [NCH];
    logic [63:0]               sq_sum [NCH];
    int unsigned               smp_cnt [NCH];
    logic                      mode_true;
    int unsigned               blk_len;

    t_in_item  pending_q [$];
    t_out_item level_q [$];
    int        errors;
    int        idle_cyc;
    int        hold_off;

    function automatic logic [LEVEL_W-1:0] sat24(input logic [63:0] v);
        return (v > 64'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
    endfunction

    function automatic logic [63:0] mag64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint tap(input int k, input int j);
        longint c [4][4];
        c = '{'{-871937, 1961861, 7847451, -1307910},
              '{-1587183, 4232481, 6348725, -1813919},
              '{-1813919, 6348725, 4232481, -1587183},
              '{-1307910, 7847451, 1961861, -871937}};
        return c[k][j];
    endfunction

    // Update channel state for one accepted request; push a level result when a block closes.
    task automatic predict_levels(input t_in_item it);
        int ch;
        logic [LEVEL_W-1:0] pk;
        logic [63:0] a;
        logic [63:0] sq;
        logic [63:0] m;
        longint acc;
        int unsigned len;
        t_out_item r;
        ch = it.channel;
        pk = peak_acc[ch];
        if (smp_cnt[ch] == 0) begin
            pk = 0;
            for (int k = 0; k < 4; k++) begin
                m = mag64(longint'(hist[ch][k]));
                if (sat24(m) > pk) pk = sat24(m);
            end
        end
        for (int k = 0; k < 3; k++) hist[ch][k] = hist[ch][k+1];
        hist[ch][3] = $signed(it.sample);
        a = mag64(longint'($signed(it.sample)));
        if (sat24(a) > pk) pk = sat24(a);
        if (mode_true) begin
            for (int k = 0; k < 4; k++) begin
                acc = 0;
                for (int j = 0; j < 4; j++) acc += longint'(hist[ch][j]) * tap(k, j);
                m = (mag64(acc) + (64'd1 << 22)) >> 23;
                if (sat24(m) > pk) pk = sat24(m);
            end
        end
        peak_acc[ch] = pk;
        sq = a * a;
        sq_sum[ch] = (sq_sum[ch] > ~64'd0 - sq) ? ~64'd0 : sq_sum[ch] + sq;
        len = blk_len;
        if (len < 4) len = 4;
        if (len > MAX_BLK) len = MAX_BLK;
        smp_cnt[ch]++;
        if (smp_cnt[ch] >= len) begin
            r.out_channel = it.channel;
            r.peak_level  = pk;
            r.rms_level   = sat24(int_sqrt(sq_sum[ch] / 64'(len)));
            level_q.push_back(r);
            smp_cnt[ch] = 0;
            sq_sum[ch]  = 0;
            peak_acc[ch] = 0;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver
    int src_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_in.valid <= 1'b0;
            s_in.data  <= '0;
            src_gap    <= 0;
        end else if (s_in.valid && s_in.ready) begin
            predict_levels(t_in_item'(s_in.data));
            void'(pending_q.pop_front());
            src_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            s_in.valid <= 1'b0;
        end else if (!s_in.valid) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
            end else if (pending_q.size() > 0) begin
                s_in.valid <= 1'b1;
                s_in.data  <= pending_q[0];
            end
        end
    end

    // Monitor
    int snk_gap;
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            m_out.ready <= 1'b0;
            snk_gap     <= 0;
            hold_off    <= 0;
        end else begin
            if (m_out.valid && m_out.ready) begin
                got = t_out_item'(m_out.data);
                if (level_q.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %h", $time, got);
                    errors++;
                end else begin
                    want = level_q.pop_front();
                    if (got.out_channel !== want.out_channel) begin
                        $display("%0t: out_channel expected %0d actual %0d", $time,
                                 want.out_channel, got.out_channel);
                        errors++;
                    end
                    if (got.peak_level !== want.peak_level) begin
                        $display("%0t: peak_level expected %0d actual %0d", $time,
                                 want.peak_level, got.peak_level);
                        errors++;
                    end
                    if (got.rms_level !== want.rms_level) begin
                        $display("%0t: rms_level expected %0d actual %0d", $time,
                                 want.rms_level, got.rms_level);
                        errors++;
                    end
                end
                snk_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
                m_out.ready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off    <= hold_off - 1;
                m_out.ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap     <= snk_gap - 1;
                m_out.ready <= 1'b0;
            end else begin
                m_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_in.valid && s_in.ready) || (m_out.valid && m_out.ready)) begin
            idle_cyc <= 0;
        end else begin
            idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WDOG_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic add_item(input int ch, input logic [LEVEL_W-1:0] smp);
        t_in_item it;
        it.channel = ch[CH_W-1:0];
        it.sample  = smp;
        pending_q.push_back(it);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_PEAK_MODE) mode_true = val[0];
        else blk_len = val[CFG_W-1:0];
    endtask

    task automatic drain_all();
        wait (pending_q.size() == 0 && !s_in.valid);
        wait (level_q.size() == 0);
        repeat (TAIL_CYC) @(posedge i_clk);
    endtask

    // Random samples: half uniform 24-bit values, the rest full-scale extremes or small noise.
    function automatic logic [LEVEL_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic random_phase(input int n, input int nch);
        for (int i = 0; i < n; i++) add_item($urandom_range(0, nch - 1), rand_sample());
    endtask

    initial begin
        errors = 0;
        idle_cyc = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_data = '0;
        s_in.valid = 1'b0;
        s_in.data = '0;
        m_out.ready = 1'b0;
        mode_true = 1'b0;
        blk_len = 1024;
        for (int c = 0; c < NCH; c++) begin
            for (int k = 0; k < 4; k++) hist[c][k] = '0;
            peak_acc[c] = 0;
            sq_sum[c] = 0;
            smp_cnt[c] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: smallest block, sample peak, extremes on channels 0 and 7.
        write_reg(CFG_BLOCK_LENGTH, 4);
        add_item(0, 24'h7FFFFF); add_item(0, 24'h800000);
        add_item(0, 24'h000000); add_item(0, 24'hFFFFFF);
        add_item(7, 24'h800000); add_item(7, 24'h800000);
        add_item(7, 24'h800000); add_item(7, 24'h800000);
        drain_all();
        // True peak: alternating full scale overshoots; block start takes history.
        write_reg(CFG_PEAK_MODE, 1);
        add_item(0, 24'h7FFFFF); add_item(0, 24'h800000);
        add_item(0, 24'h7FFFFF); add_item(0, 24'h800000);
        add_item(7, 24'h000001); add_item(7, 24'h000000);
        add_item(7, 24'h000000); add_item(7, 24'h000000);
        add_item(3, 24'h555555); add_item(3, 24'hAAAAAA);
        add_item(3, 24'h400000); add_item(3, 24'hC00000);
        drain_all();
        // Length below range acts as four; odd length counted sample by sample.
        write_reg(CFG_BLOCK_LENGTH, 0);
        random_phase(8, 2);
        drain_all();
        write_reg(CFG_BLOCK_LENGTH, 5);
        random_phase(10, 1);
        drain_all();
        // Length drop below current count closes the block on the next sample.
        write_reg(CFG_BLOCK_LENGTH, 8);
        random_phase(6, 1);
        drain_all();
        write_reg(CFG_BLOCK_LENGTH, 4);
        random_phase(2, 1);
        drain_all();

        // Random phases, short blocks; long sink stall to back up the input.
        write_reg(CFG_PEAK_MODE, 1);
        write_reg(CFG_BLOCK_LENGTH, 4);
        hold_off = 600;
        random_phase(120, 8);
        drain_all();
        write_reg(CFG_PEAK_MODE, 0);
        write_reg(CFG_BLOCK_LENGTH, 8);
        random_phase(100, 4);
        drain_all();
        write_reg(CFG_PEAK_MODE, 1);
        write_reg(CFG_BLOCK_LENGTH, 12);
        random_phase(110, 3);
        drain_all();
        // Out-of-range length clamps to the largest block; open block then cut short.
        write_reg(CFG_BLOCK_LENGTH, 8191);
        random_phase(20, 1);
        drain_all();
        write_reg(CFG_BLOCK_LENGTH, 16);
        random_phase(60, 8);
        drain_all();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/atprm_pkg.sv
rtl/atprm_if.sv
rtl/audio_true_peak_rms_meter.sv
tb/sv/tb_top.sv
